>>> rtl/kplc_pkg.sv
// Shared types and constants for the keypad password lock controller.
package kplc_pkg;

	localparam int unsigned DIGIT_W     = 4;
	localparam int unsigned THRESH_W    = 9;
	localparam int unsigned SAMPLE_W    = 10;
	localparam int unsigned DEV_W       = 7;
	localparam int unsigned MODE_W      = 2;
	localparam int unsigned STATUS_W    = 3;
	localparam int unsigned COUNT_W     = 3;
	localparam int unsigned PASS_LEN    = 4;
	localparam int unsigned APB_DATA_W  = 32;
	localparam int unsigned APB_ADDR_W  = 5;
	localparam int unsigned REG_IDX_W   = 3;

	localparam logic [REG_IDX_W-1:0] REG_PASS_0    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_PASS_1    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_PASS_2    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_PASS_3    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_FAN_THRSH = 3'd4;

	localparam logic [DIGIT_W-1:0]  RST_PASS_0    = 4'd1;
	localparam logic [DIGIT_W-1:0]  RST_PASS_1    = 4'd2;
	localparam logic [DIGIT_W-1:0]  RST_PASS_2    = 4'd3;
	localparam logic [DIGIT_W-1:0]  RST_PASS_3    = 4'd4;
	localparam logic [THRESH_W-1:0] RST_FAN_THRSH = 9'd30;

	localparam logic [MODE_W-1:0] MODE_WELCOME = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ENTRY   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_MENU    = 2'd2;
	localparam logic [MODE_W-1:0] MODE_LIGHTS  = 2'd3;

	localparam logic [STATUS_W-1:0] ST_NONE    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_OK      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BAD     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_INVALID = 3'd3;
	localparam logic [STATUS_W-1:0] ST_LOGOUT  = 3'd4;

	localparam logic [DIGIT_W-1:0] KEY_DIGIT_MAX = 4'd9;
	localparam logic [DIGIT_W-1:0] KEY_STAR      = 4'd10;
	localparam logic [DIGIT_W-1:0] KEY_HASH      = 4'd11;

	localparam logic [DIGIT_W-1:0] MENU_KEY_LOGOUT = 4'd1;
	localparam logic [DIGIT_W-1:0] MENU_KEY_TV     = 4'd2;
	localparam logic [DIGIT_W-1:0] MENU_KEY_LIGHTS = 4'd3;
	localparam logic [DIGIT_W-1:0] MENU_KEY_DOOR   = 4'd4;

	localparam logic [DIGIT_W-1:0] LIGHTS_KEY_ROOM1 = 4'd1;
	localparam logic [DIGIT_W-1:0] LIGHTS_KEY_ROOM2 = 4'd2;
	localparam logic [DIGIT_W-1:0] LIGHTS_KEY_MAIN  = 4'd3;
	localparam logic [DIGIT_W-1:0] LIGHTS_KEY_BACK  = 4'd4;

	localparam logic [DEV_W-1:0] DEV_FAN   = 7'h01;
	localparam logic [DEV_W-1:0] DEV_TV    = 7'h02;
	localparam logic [DEV_W-1:0] DEV_ROOM1 = 7'h04;
	localparam logic [DEV_W-1:0] DEV_ROOM2 = 7'h08;
	localparam logic [DEV_W-1:0] DEV_MAIN  = 7'h30;
	localparam logic [DEV_W-1:0] DEV_DOOR  = 7'h40;

	localparam logic [COUNT_W-1:0] COUNT_FULL = 3'd4;

	typedef struct packed {
		logic                op;
		logic [DIGIT_W-1:0]  key_code;
		logic [SAMPLE_W-1:0] sample;
	} item_t;

	typedef struct packed {
		logic [DEV_W-1:0]    device_bits;
		logic [MODE_W-1:0]   mode;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  digit_count;
	} result_t;

	typedef struct packed {
		logic [PASS_LEN-1:0][DIGIT_W-1:0] pass_digit;
		logic [THRESH_W-1:0]              fan_threshold;
	} cfg_t;

endpackage

>>> rtl/kplc_stream_if.sv
// Request and result channel interfaces for the keypad password lock controller.
interface kplc_req_if;
	logic                            valid;
	logic                            ready;
	logic                            op;
	logic [kplc_pkg::DIGIT_W-1:0]    key_code;
	logic [kplc_pkg::SAMPLE_W-1:0]   sample;

	modport source (output valid, output op, output key_code, output sample, input ready);
	modport sink   (input valid, input op, input key_code, input sample, output ready);
endinterface

interface kplc_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [kplc_pkg::DEV_W-1:0]      device_bits;
	logic [kplc_pkg::MODE_W-1:0]     mode;
	logic [kplc_pkg::STATUS_W-1:0]   status;
	logic [kplc_pkg::COUNT_W-1:0]    digit_count;

	modport source (output valid, output device_bits, output mode, output status,
		output digit_count, input ready);
	modport sink   (input valid, input device_bits, input mode, input status,
		input digit_count, output ready);
endinterface

>>> rtl/kplc_regs.sv
// APB configuration registers: password digits and fan threshold.
module kplc_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [kplc_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [kplc_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [kplc_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready,
	output kplc_pkg::cfg_t                    cfg
);

	localparam int unsigned PAD_DIGIT  = kplc_pkg::APB_DATA_W - kplc_pkg::DIGIT_W;
	localparam int unsigned PAD_THRESH = kplc_pkg::APB_DATA_W - kplc_pkg::THRESH_W;

	kplc_pkg::cfg_t                   cfg_q;
	logic [kplc_pkg::REG_IDX_W-1:0]   idx;
	logic                             wr;

	assign pready = 1'b1;
	assign idx    = paddr[kplc_pkg::APB_ADDR_W-1:2];
	assign wr     = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pass_digit[0] <= kplc_pkg::RST_PASS_0;
			cfg_q.pass_digit[1] <= kplc_pkg::RST_PASS_1;
			cfg_q.pass_digit[2] <= kplc_pkg::RST_PASS_2;
			cfg_q.pass_digit[3] <= kplc_pkg::RST_PASS_3;
			cfg_q.fan_threshold <= kplc_pkg::RST_FAN_THRSH;
		end else if (wr) begin
			unique case (idx)
				kplc_pkg::REG_PASS_0:    cfg_q.pass_digit[0] <= pwdata[kplc_pkg::DIGIT_W-1:0];
				kplc_pkg::REG_PASS_1:    cfg_q.pass_digit[1] <= pwdata[kplc_pkg::DIGIT_W-1:0];
				kplc_pkg::REG_PASS_2:    cfg_q.pass_digit[2] <= pwdata[kplc_pkg::DIGIT_W-1:0];
				kplc_pkg::REG_PASS_3:    cfg_q.pass_digit[3] <= pwdata[kplc_pkg::DIGIT_W-1:0];
				kplc_pkg::REG_FAN_THRSH: cfg_q.fan_threshold <= pwdata[kplc_pkg::THRESH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			kplc_pkg::REG_PASS_0:    prdata = {{PAD_DIGIT{1'b0}}, cfg_q.pass_digit[0]};
			kplc_pkg::REG_PASS_1:    prdata = {{PAD_DIGIT{1'b0}}, cfg_q.pass_digit[1]};
			kplc_pkg::REG_PASS_2:    prdata = {{PAD_DIGIT{1'b0}}, cfg_q.pass_digit[2]};
			kplc_pkg::REG_PASS_3:    prdata = {{PAD_DIGIT{1'b0}}, cfg_q.pass_digit[3]};
			kplc_pkg::REG_FAN_THRSH: prdata = {{PAD_THRESH{1'b0}}, cfg_q.fan_threshold};
			default:                 prdata = '0;
		endcase
	end

endmodule

>>> rtl/kplc_core.sv
// Lock state, entered digits and device bits with the per-request update logic.
module kplc_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  kplc_pkg::item_t   item,
	input  kplc_pkg::cfg_t    cfg,
	output kplc_pkg::result_t result
);

	logic [kplc_pkg::MODE_W-1:0]   mode_q, mode_d;
	logic [kplc_pkg::COUNT_W-1:0]  count_q, count_d;
	logic [kplc_pkg::DEV_W-1:0]    bits_q, bits_d;
	logic [kplc_pkg::STATUS_W-1:0] status;
	logic [kplc_pkg::DIGIT_W-1:0]  digits_q [kplc_pkg::PASS_LEN];
	logic                          digit_wr;
	logic                          match;

	assign match = (count_q == kplc_pkg::COUNT_FULL)
		&& (digits_q[0] == cfg.pass_digit[0])
		&& (digits_q[1] == cfg.pass_digit[1])
		&& (digits_q[2] == cfg.pass_digit[2])
		&& (digits_q[3] == cfg.pass_digit[3]);

	always_comb begin
		mode_d   = mode_q;
		count_d  = count_q;
		bits_d   = bits_q;
		status   = kplc_pkg::ST_NONE;
		digit_wr = 1'b0;
		if (item.op) begin
			if (item.sample[kplc_pkg::SAMPLE_W-1:1] > cfg.fan_threshold) begin
				bits_d = bits_q | kplc_pkg::DEV_FAN;
			end else begin
				bits_d = bits_q & ~kplc_pkg::DEV_FAN;
			end
		end else begin
			unique case (mode_q)
				kplc_pkg::MODE_WELCOME: begin
					if (item.key_code == kplc_pkg::KEY_STAR) begin
						mode_d = kplc_pkg::MODE_ENTRY;
					end
				end
				kplc_pkg::MODE_ENTRY: begin
					priority if (item.key_code == kplc_pkg::KEY_HASH) begin
						if (match) begin
							mode_d = kplc_pkg::MODE_MENU;
							status = kplc_pkg::ST_OK;
						end else begin
							status = kplc_pkg::ST_BAD;
						end
					end else if (item.key_code == kplc_pkg::KEY_STAR) begin
						count_d = '0;
					end else if (item.key_code > kplc_pkg::KEY_DIGIT_MAX) begin
						status = kplc_pkg::ST_INVALID;
					end else if (count_q < kplc_pkg::COUNT_FULL) begin
						digit_wr = 1'b1;
						count_d  = count_q + 1'b1;
					end else begin
						status = kplc_pkg::ST_NONE;
					end
				end
				kplc_pkg::MODE_MENU: begin
					unique case (item.key_code)
						kplc_pkg::MENU_KEY_LOGOUT: begin
							bits_d  = bits_q & kplc_pkg::DEV_FAN;
							count_d = '0;
							mode_d  = kplc_pkg::MODE_WELCOME;
							status  = kplc_pkg::ST_LOGOUT;
						end
						kplc_pkg::MENU_KEY_TV:     bits_d = bits_q ^ kplc_pkg::DEV_TV;
						kplc_pkg::MENU_KEY_LIGHTS: mode_d = kplc_pkg::MODE_LIGHTS;
						kplc_pkg::MENU_KEY_DOOR:   bits_d = bits_q ^ kplc_pkg::DEV_DOOR;
						default:                   status = kplc_pkg::ST_INVALID;
					endcase
				end
				default: begin
					unique case (item.key_code)
						kplc_pkg::LIGHTS_KEY_ROOM1: bits_d = bits_q ^ kplc_pkg::DEV_ROOM1;
						kplc_pkg::LIGHTS_KEY_ROOM2: bits_d = bits_q ^ kplc_pkg::DEV_ROOM2;
						kplc_pkg::LIGHTS_KEY_MAIN:  bits_d = bits_q ^ kplc_pkg::DEV_MAIN;
						kplc_pkg::LIGHTS_KEY_BACK:  mode_d = kplc_pkg::MODE_MENU;
						default:                    status = kplc_pkg::ST_INVALID;
					endcase
				end
			endcase
		end
	end

	assign result.device_bits = bits_d;
	assign result.mode        = mode_d;
	assign result.status      = status;
	assign result.digit_count = count_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= kplc_pkg::MODE_WELCOME;
			count_q <= '0;
			bits_q  <= '0;
		end else if (advance) begin
			mode_q  <= mode_d;
			count_q <= count_d;
			bits_q  <= bits_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && digit_wr) begin
			digits_q[count_q[1:0]] <= item.key_code;
		end
	end

endmodule

>>> rtl/keypad_password_lock_controller.sv
// Top level of the keypad password lock controller: request and result stages.
//
// Requests arrive on req (valid/ready): op 0 carries a decoded key in key_code,
// op 1 carries a ten-bit temperature reading in sample. Every request gives
// exactly one result on rsp: device_bits, mode, status and digit_count after
// that request.
// A request is registered on acceptance, updated against the lock state while it
// sits in the request register and placed in the result register, which drives
// rsp.valid; a full result register with rsp.ready low holds it back.
// One request per cycle is taken while the result register can load, set by the
// single state update between the request and result registers.
// When rsp.ready is low a full result register holds and the request register
// still takes one more request; req.ready drops only when both are full.
// The APB port holds the four password digits (0x0 to 0xC) and the fan
// threshold (0x10); writes complete in the access cycle, pready is always high.
// Reset (arst_n low) empties both stages, returns to welcome with no digits
// and all devices off, and restores password 1234 and threshold 30.
module keypad_password_lock_controller (
	input  logic                              clk,
	input  logic                              arst_n,
	kplc_req_if.sink                          req,
	kplc_rsp_if.source                        rsp,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [kplc_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [kplc_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [kplc_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready
);

	kplc_pkg::cfg_t    cfg;
	kplc_pkg::item_t   item_s1;
	kplc_pkg::result_t result;
	kplc_pkg::result_t result_s2;
	logic              valid_s1;
	logic              valid_s2;
	logic              load_s2;
	logic              advance;
	logic              req_acc;

	kplc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	kplc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (result)
	);

	assign load_s2   = !valid_s2 || rsp.ready;
	assign advance   = valid_s1 && load_s2;
	assign req.ready = !valid_s1 || load_s2;
	assign req_acc   = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			item_s1.op       <= req.op;
			item_s1.key_code <= req.key_code;
			item_s1.sample   <= req.sample;
		end
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign rsp.valid       = valid_s2;
	assign rsp.device_bits = result_s2.device_bits;
	assign rsp.mode        = result_s2.mode;
	assign rsp.status      = result_s2.status;
	assign rsp.digit_count = result_s2.digit_count;

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(req_acc && valid_s1 && valid_s2 && !rsp.ready))
		else $error("request taken while both stages are blocked");

	a_logout_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == kplc_pkg::ST_LOGOUT) |->
		(rsp.mode == kplc_pkg::MODE_WELCOME && rsp.digit_count == '0
		&& rsp.device_bits[kplc_pkg::DEV_W-1:1] == '0))
		else $error("logout left state behind");

	a_accept_full: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == kplc_pkg::ST_OK) |->
		(rsp.mode == kplc_pkg::MODE_MENU && rsp.digit_count == kplc_pkg::COUNT_FULL))
		else $error("password accepted without four digits or menu");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> (result.digit_count <= kplc_pkg::COUNT_FULL))
		else $error("digit count beyond four");

endmodule
